// ----- rtl/core/nlt_pkg.sv -----
// Package for the node location table: widths, operation and status codes,
// beat payload structs and the token that travels along the cell chain.
// No dependencies.
package nlt_pkg;

  parameter int unsigned TableDepth = 128;
  parameter int unsigned CountW     = $clog2(TableDepth + 1);
  parameter int unsigned NodeW      = 32;
  parameter int unsigned UnitW      = 12;
  parameter int unsigned AddrW      = 32;
  parameter int unsigned UnitCountW = 13;
  parameter int unsigned DivSteps   = NodeW;
  parameter int unsigned DivCntW    = $clog2(DivSteps + 1);

  typedef enum logic [1:0] {
    OpRegister = 2'd0,
    OpResolve  = 2'd1,
    OpAddress  = 2'd2,
    OpFindUnit = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StFallback = 2'd3
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [NodeW-1:0] node_id;
    logic [UnitW-1:0] unit_id;
    logic [AddrW-1:0] unit_address;
  } nlt_in_t;

  typedef struct packed {
    status_e          status;
    logic [NodeW-1:0] node_out;
    logic [UnitW-1:0] unit_out;
    logic [AddrW-1:0] address_out;
  } nlt_out_t;

  // The query plus the first match seen so far. remain counts the valid
  // entries still ahead of the token.
  typedef struct packed {
    op_e               op;
    logic [NodeW-1:0]  node;
    logic [UnitW-1:0]  unit;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] remain;
    logic              found;
    logic [NodeW-1:0]  res_node;
    logic [UnitW-1:0]  res_unit;
    logic [AddrW-1:0]  res_address;
  } nlt_token_t;

endpackage

// ----- rtl/core/nlt_cell.sv -----
// One table entry of the node location table and its stage of the chain.
// Depends on nlt_pkg.
module nlt_cell
  import nlt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  nlt_token_t in_tok_i,
  output logic       out_valid_o,
  output nlt_token_t out_tok_o
);

  logic [NodeW-1:0] node_q;
  logic [UnitW-1:0] unit_q;
  logic [AddrW-1:0] addr_q;
  logic             valid_q;
  nlt_token_t       tok_q, tok_d;
  logic             hit;
  logic             wr_en;

  always_comb begin
    tok_d = in_tok_i;
    hit   = 1'b0;
    unique case (in_tok_i.op)
      OpResolve:  hit = (addr_q == in_tok_i.address) && (unit_q == in_tok_i.unit);
      OpAddress:  hit = (node_q == in_tok_i.node) && (unit_q == in_tok_i.unit);
      OpFindUnit: hit = (node_q == in_tok_i.node);
      OpRegister: hit = 1'b0;
      default:    hit = 1'b0;
    endcase
    wr_en = in_valid_i && (in_tok_i.op == OpRegister) && (in_tok_i.remain == '0)
            && !in_tok_i.found;
    if (in_tok_i.remain != '0) begin
      tok_d.remain = in_tok_i.remain - 1'b1;
      if (!in_tok_i.found && hit) begin
        tok_d.found       = 1'b1;
        tok_d.res_node    = node_q;
        tok_d.res_unit    = unit_q;
        tok_d.res_address = addr_q;
      end
    end
    if (wr_en) begin
      tok_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      tok_q <= tok_d;
    end
    if (wr_en) begin
      node_q <= in_tok_i.node;
      unit_q <= in_tok_i.unit;
      addr_q <= in_tok_i.address;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;

endmodule

// ----- rtl/core/nlt_divider.sv -----
// Restoring divider, one quotient bit per cycle, that yields node modulo
// the unit count for the fallback unit. Depends on nlt_pkg.
module nlt_divider
  import nlt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NodeW-1:0]      dividend_i,
  input  logic [UnitCountW-1:0] divisor_i,
  output logic                  busy_o,
  output logic [UnitCountW-1:0] remainder_o
);

  logic [DivCntW-1:0]    cnt_q;
  logic                  busy_q;
  logic [NodeW-1:0]      dividend_q;
  logic [UnitCountW-1:0] div_q, rem_q, rem_d;
  logic [UnitCountW:0]   trial;

  always_comb begin
    trial = {rem_q, dividend_q[NodeW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = UnitCountW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[UnitCountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(DivSteps);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      div_q      <= (divisor_i == '0) ? UnitCountW'(1) : divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      dividend_q <= {dividend_q[NodeW-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/core/node_location_table.sv -----
// Top level of the node location table: a chain of entry cells that a query
// token walks, plus a serial divider for the fallback unit.
// Depends on nlt_pkg, nlt_cell and nlt_divider.
//
//   port group   direction  handshake              payload
//   in           sink       in_valid_i/in_ready_o   in_data_i (nlt_in_t)
//   out          source     out_valid_o/out_ready_i out_data_o (nlt_out_t)
//   cfg          sink       cfg_we_i                cfg_wdata_i (unit count)
//
// Every beat walks the whole chain of TableDepth cells from acceptance to a
// valid result, and beats are taken one at a time; the serial divider runs
// beside the chain and finishes first.
// A new beat is taken once the previous result sits in the output register.
// Reset empties the table at once and sets the unit count to one.
// A stalled output holds the block in its wait state until the beat leaves.
module node_location_table
  import nlt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nlt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nlt_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [UnitCountW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait
  } state_e;

  state_e                state_q;
  logic [CountW-1:0]     count_q;
  logic [UnitCountW-1:0] unit_count_q;
  logic                  full_q;
  nlt_token_t            res_q;
  logic                  out_valid_q;
  nlt_out_t              out_q, out_d;
  logic                  accept;
  logic                  full;
  logic                  div_busy;
  logic [UnitCountW-1:0] div_rem;
  logic                  finish;

  logic       chain_valid [TableDepth+1];
  nlt_token_t chain_tok   [TableDepth+1];

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_ready_o = (state_q == StIdle);
  assign full       = (count_q == CountW'(TableDepth));
  assign finish     = (state_q == StWait) && !div_busy && (!out_valid_q || out_ready_i);

  always_comb begin
    chain_valid[0]         = accept;
    chain_tok[0]           = '0;
    chain_tok[0].op        = in_data_i.operation;
    chain_tok[0].node      = in_data_i.node_id;
    chain_tok[0].unit      = in_data_i.unit_id;
    chain_tok[0].address   = in_data_i.unit_address;
    chain_tok[0].remain    = count_q;
    chain_tok[0].found     = (in_data_i.operation == OpRegister) && full;
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    nlt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_tok_i    (chain_tok[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_tok_o   (chain_tok[g+1])
    );
  end

  nlt_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .dividend_i  (in_data_i.node_id),
    .divisor_i   (unit_count_q),
    .busy_o      (div_busy),
    .remainder_o (div_rem)
  );

  always_comb begin
    out_d = '0;
    unique case (res_q.op)
      OpRegister: begin
        out_d.status = full_q ? StFull : StOk;
      end
      OpResolve: begin
        out_d.status = res_q.found ? StOk : StNotFound;
        if (res_q.found) begin
          out_d.node_out = res_q.res_node;
        end
      end
      OpAddress: begin
        out_d.status = res_q.found ? StOk : StNotFound;
        if (res_q.found) begin
          out_d.address_out = res_q.res_address;
        end
      end
      OpFindUnit: begin
        out_d.status   = res_q.found ? StOk : StFallback;
        out_d.unit_out = res_q.found ? res_q.res_unit : div_rem[UnitW-1:0];
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      unit_count_q <= UnitCountW'(1);
      out_valid_q  <= 1'b0;
      full_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_count_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StScan;
            full_q  <= full;
            if ((in_data_i.operation == OpRegister) && !full) begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        StScan: begin
          if (chain_valid[TableDepth]) begin
            state_q <= StWait;
          end
        end
        StWait: begin
          if (finish) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[TableDepth]) begin
      res_q <= chain_tok[TableDepth];
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
